// ===== src/bcp_pkg.sv =====
`default_nettype none
package bcp_pkg;

  typedef enum logic [3:0] {
    PH_LEAD,
    PH_PREFIX,
    PH_AFTER_PREFIX,
    PH_LIST,
    PH_KEY,
    PH_KEY_WS,
    PH_EQ_WS,
    PH_TOKEN,
    PH_QUOTED,
    PH_AFTER_PARAM
  } phase_e;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_FINAL = 2'd2;

  localparam logic [1:0] FLD_REALM   = 2'd0;
  localparam logic [1:0] FLD_SERVICE = 2'd1;
  localparam logic [1:0] FLD_SCOPE   = 2'd2;
  localparam logic [1:0] FLD_ERROR   = 2'd3;

  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;

  localparam logic [2:0] PREFIX_LEN = 3'd6;
  localparam logic [3:0] ALL_NAMES  = 4'hf;

  localparam int FIFO_DEPTH = 4;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] field_id;
    logic [7:0] value_char;
    logic       accepted;
    logic       final_flag;
  } res_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c inside {[8'h41:8'h5a]}) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB);
  endfunction

  function automatic logic [7:0] bearer_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0: ch = "b";
      3'd1: ch = "e";
      3'd2: ch = "a";
      3'd3: ch = "r";
      3'd4: ch = "e";
      3'd5: ch = "r";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] name_len(input logic [1:0] fid);
    return (fid == FLD_SERVICE) ? 3'd7 : 3'd5;
  endfunction

  function automatic logic [7:0] name_char(input logic [1:0] fid, input logic [2:0] idx);
    logic [55:0] txt;
    case (fid)
      FLD_REALM:   txt = {"realm", 16'h0000};
      FLD_SERVICE: txt = "service";
      FLD_SCOPE:   txt = {"scope", 16'h0000};
      FLD_ERROR:   txt = {"error", 16'h0000};
      default:     txt = '0;
    endcase
    case (idx)
      3'd0: return txt[55:48];
      3'd1: return txt[47:40];
      3'd2: return txt[39:32];
      3'd3: return txt[31:24];
      3'd4: return txt[23:16];
      3'd5: return txt[15:8];
      3'd6: return txt[7:0];
      default: return 8'h00;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== src/bcp_core.sv =====
`default_nettype none
module bcp_core import bcp_pkg::*; #(
  parameter int KEY_CAP   = 32,
  parameter int VALUE_CAP = 512,
  parameter int FIELD_CAP = 256
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       go_i,
  input  wire logic [7:0] data_i,
  input  wire logic       last_i,
  output logic            a_vld_o,
  output res_t            a_res_o,
  output logic            fin_vld_o,
  output res_t            fin_res_o
);

  localparam int KW = $clog2(KEY_CAP);
  localparam int VW = $clog2(VALUE_CAP);
  localparam int LW = $clog2(VALUE_CAP + FIELD_CAP + 1);

  phase_e          phase_q, phase_d;
  logic [2:0]      pcnt_q, pcnt_d;
  logic [3:0]      cand_q, cand_d;
  logic [KW-1:0]   klen_q, klen_d;
  logic [VW-1:0]   vlen_q, vlen_d;
  logic [1:0]      fld_q, fld_d;
  logic            known_q, known_d;
  logic            esc_q, esc_d;
  logic            failed_q, failed_d;
  logic            realm_q, realm_d;

  logic [7:0] lc;
  logic       do_tok, do_key, do_val, do_end, a_vld;
  res_t       a_res;

  always_comb begin
    phase_d  = phase_q;
    pcnt_d   = pcnt_q;
    cand_d   = cand_q;
    klen_d   = klen_q;
    vlen_d   = vlen_q;
    fld_d    = fld_q;
    known_d  = known_q;
    esc_d    = esc_q;
    failed_d = failed_q;
    realm_d  = realm_q;
    lc       = to_lower(data_i);
    do_tok   = 1'b0;
    do_key   = 1'b0;
    do_val   = 1'b0;
    do_end   = 1'b0;
    a_vld    = 1'b0;
    a_res    = '0;

    if (!failed_q) begin
      case (phase_q)
        PH_LEAD, PH_PREFIX: begin
          if (!(phase_q == PH_LEAD && is_ws(data_i))) begin
            if (pcnt_q < PREFIX_LEN && lc == bearer_char(pcnt_q)) begin
              pcnt_d  = pcnt_q + 3'd1;
              phase_d = (pcnt_d == PREFIX_LEN) ? PH_AFTER_PREFIX : PH_PREFIX;
            end else begin
              failed_d = 1'b1;
            end
          end
        end
        PH_AFTER_PREFIX: begin
          if (is_ws(data_i)) phase_d = PH_LIST;
          else failed_d = 1'b1;
        end
        PH_LIST: begin
          if (is_ws(data_i) || data_i == CH_COMMA) begin
            phase_d = PH_LIST;
          end else if (data_i == CH_EQ) begin
            failed_d = 1'b1;
          end else begin
            cand_d  = ALL_NAMES;
            klen_d  = '0;
            phase_d = PH_KEY;
            do_key  = 1'b1;
          end
        end
        PH_KEY: begin
          if (data_i == CH_EQ) begin
            do_end  = 1'b1;
            phase_d = PH_EQ_WS;
          end else if (data_i == CH_COMMA) begin
            do_end  = 1'b1;
            phase_d = PH_LIST;
          end else if (is_ws(data_i)) begin
            do_end  = 1'b1;
            phase_d = PH_KEY_WS;
          end else begin
            do_key = 1'b1;
          end
        end
        PH_KEY_WS: begin
          if (is_ws(data_i)) phase_d = PH_KEY_WS;
          else if (data_i == CH_EQ) phase_d = PH_EQ_WS;
          else if (data_i == CH_COMMA) phase_d = PH_LIST;
          else failed_d = 1'b1;
        end
        PH_EQ_WS: begin
          if (is_ws(data_i)) begin
            phase_d = PH_EQ_WS;
          end else if (data_i == CH_DQUOTE) begin
            esc_d   = 1'b0;
            phase_d = PH_QUOTED;
          end else begin
            do_tok = 1'b1;
          end
        end
        PH_TOKEN: do_tok = 1'b1;
        PH_QUOTED: begin
          if (esc_q) begin
            esc_d  = 1'b0;
            do_val = 1'b1;
          end else if (data_i == CH_DQUOTE) begin
            phase_d = PH_AFTER_PARAM;
          end else if (data_i == CH_BSLASH) begin
            esc_d = 1'b1;
          end else begin
            do_val = 1'b1;
          end
        end
        PH_AFTER_PARAM: begin
          if (is_ws(data_i)) phase_d = PH_AFTER_PARAM;
          else if (data_i == CH_COMMA) phase_d = PH_LIST;
          else failed_d = 1'b1;
        end
        default: failed_d = 1'b1;
      endcase
    end

    if (do_tok) begin
      if (data_i == CH_COMMA) begin
        phase_d = PH_LIST;
      end else if (is_ws(data_i)) begin
        phase_d = PH_AFTER_PARAM;
      end else begin
        phase_d = PH_TOKEN;
        do_val  = 1'b1;
      end
    end

    if (do_key) begin
      if (klen_d >= KW'(KEY_CAP - 1)) begin
        failed_d = 1'b1;
      end else begin
        for (int j = 0; j < 4; j++) begin
          if (klen_d >= KW'(name_len(2'(j))) || lc != name_char(2'(j), klen_d[2:0])) begin
            cand_d[j] = 1'b0;
          end
        end
        klen_d = klen_d + KW'(1);
      end
    end

    if (do_val) begin
      if (vlen_d >= VW'(VALUE_CAP - 1)) begin
        failed_d = 1'b1;
      end else begin
        vlen_d = vlen_d + VW'(1);
        if (known_d) begin
          if (LW'(vlen_d) >= LW'(FIELD_CAP)) begin
            failed_d = 1'b1;
          end else begin
            if (fld_d == FLD_REALM) realm_d = 1'b1;
            a_vld          = 1'b1;
            a_res.kind     = KIND_VALUE;
            a_res.field_id = fld_d;
            a_res.value_char = data_i;
          end
        end
      end
    end

    if (last_i && !failed_d) begin
      if (phase_d inside {PH_LEAD, PH_PREFIX, PH_QUOTED}) failed_d = 1'b1;
      else if (phase_d == PH_KEY) do_end = 1'b1;
    end

    if (do_end) begin
      known_d = 1'b0;
      vlen_d  = '0;
      for (int j = 0; j < 4; j++) begin
        if (cand_d[j] && klen_d == KW'(name_len(2'(j)))) begin
          known_d = 1'b1;
          fld_d   = 2'(j);
        end
      end
      if (known_d) begin
        if (fld_d == FLD_REALM) realm_d = 1'b0;
        a_vld          = 1'b1;
        a_res.kind     = KIND_START;
        a_res.field_id = fld_d;
      end
    end

    fin_res_o            = '0;
    fin_res_o.kind       = KIND_FINAL;
    fin_res_o.field_id   = FLD_REALM;
    fin_res_o.accepted   = !failed_d && realm_d;
    fin_res_o.final_flag = 1'b1;

    if (last_i) begin
      phase_d  = PH_LEAD;
      pcnt_d   = '0;
      cand_d   = ALL_NAMES;
      klen_d   = '0;
      vlen_d   = '0;
      fld_d    = FLD_REALM;
      known_d  = 1'b0;
      esc_d    = 1'b0;
      failed_d = 1'b0;
      realm_d  = 1'b0;
    end
  end

  assign a_vld_o   = go_i && a_vld;
  assign a_res_o   = a_res;
  assign fin_vld_o = go_i && last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_LEAD;
      pcnt_q   <= '0;
      cand_q   <= ALL_NAMES;
      klen_q   <= '0;
      vlen_q   <= '0;
      fld_q    <= FLD_REALM;
      known_q  <= 1'b0;
      esc_q    <= 1'b0;
      failed_q <= 1'b0;
      realm_q  <= 1'b0;
    end else if (go_i) begin
      phase_q  <= phase_d;
      pcnt_q   <= pcnt_d;
      cand_q   <= cand_d;
      klen_q   <= klen_d;
      vlen_q   <= vlen_d;
      fld_q    <= fld_d;
      known_q  <= known_d;
      esc_q    <= esc_d;
      failed_q <= failed_d;
      realm_q  <= realm_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/bcp_res_fifo.sv =====
`default_nettype none
module bcp_res_fifo import bcp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic a_vld_i,
  input  wire res_t a_res_i,
  input  wire logic fin_vld_i,
  input  wire res_t fin_res_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output res_t      out_res_o
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  res_t          mem_q [FIFO_DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [1:0]    n_push;
  logic          pop;
  res_t          e0;

  assign n_push      = {1'b0, a_vld_i} + {1'b0, fin_vld_i};
  assign e0          = a_vld_i ? a_res_i : fin_res_i;
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = cnt_q != '0;
  assign out_res_o   = mem_q[rd_q];
  assign room_o      = cnt_q <= CW'(FIFO_DEPTH - 2);

  always_comb begin
    wr_d  = wr_q + PW'(n_push);
    rd_d  = rd_q + PW'(pop);
    cnt_d = cnt_q + CW'(n_push) - CW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) mem_q[wr_q] <= e0;
    if (n_push == 2'd2) mem_q[wr_q + PW'(1)] <= fin_res_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(FIFO_DEPTH))
    else $error("result buffer count beyond depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_push != 2'd0) |-> room_o)
    else $error("result push without room");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_q - rd_q) == cnt_q[PW-1:0])
    else $error("result buffer pointers disagree with count");

endmodule
`default_nettype wire

// ===== src/bearer_challenge_parser.sv =====
`default_nettype none
// Streaming parser for a Bearer challenge header value. Bytes enter one per cycle, while
// the result buffer has room, through an input register; each byte updates the parser
// state and its results (a field start or a value byte, plus the final status on the last
// byte) go into a four-entry result buffer that drains one word per cycle while the output
// is ready. A new byte is taken every cycle as long as the buffer holds at most two words,
// so the sustained rate is one byte per cycle. Only the last byte of a header can yield two
// words (a field start or a value byte together with the final status); with the output
// draining every cycle, such a byte taken while the buffer already holds two words stalls
// the input. A result is visible once its byte has passed the input register and the buffer.
module bearer_challenge_parser import bcp_pkg::*; #(
  parameter int KEY_CAP   = 32,
  parameter int VALUE_CAP = 512,
  parameter int FIELD_CAP = 256
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      kind_o,
  output logic [1:0]      field_id_o,
  output logic [7:0]      value_char_o,
  output logic            accepted_o,
  output logic            final_flag_o
);

  logic       in_vld_q, in_vld_d;
  logic [7:0] data_q;
  logic       last_q;
  logic       room, go;
  logic       a_vld, fin_vld;
  res_t       a_res, fin_res, out_res;

  assign go         = in_vld_q && room;
  assign in_ready_o = !in_vld_q || room;
  assign in_vld_d   = in_valid_i ? 1'b1 : (in_vld_q && !room);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  bcp_core #(
    .KEY_CAP  (KEY_CAP),
    .VALUE_CAP(VALUE_CAP),
    .FIELD_CAP(FIELD_CAP)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .go_i     (go),
    .data_i   (data_q),
    .last_i   (last_q),
    .a_vld_o  (a_vld),
    .a_res_o  (a_res),
    .fin_vld_o(fin_vld),
    .fin_res_o(fin_res)
  );

  bcp_res_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .a_vld_i    (a_vld),
    .a_res_i    (a_res),
    .fin_vld_i  (fin_vld),
    .fin_res_i  (fin_res),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_res_o  (out_res)
  );

  assign kind_o       = out_res.kind;
  assign field_id_o   = out_res.field_id;
  assign value_char_o = out_res.value_char;
  assign accepted_o   = out_res.accepted;
  assign final_flag_o = out_res.final_flag;

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !room) |=> (in_vld_q && $stable(data_q) && $stable(last_q)))
    else $error("stalled input word lost");

  a_final_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && final_flag_o) |-> (kind_o == KIND_FINAL && field_id_o == FLD_REALM))
    else $error("final word malformed");

  a_accept_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && accepted_o) |-> final_flag_o)
    else $error("accept flag outside final word");

endmodule
`default_nettype wire

// ===== sim/bearer_challenge_parser_test.sv =====
`timescale 1ns / 1ps

module bearer_challenge_parser_test;
  import bcp_pkg::*;

  localparam int KEY_CAP   = 32;
  localparam int VALUE_CAP = 512;
  localparam int FIELD_CAP = 256;
  localparam int STALL_LIMIT = 2000;
  localparam logic [47:0] BEARER_TXT = "bearer";

  typedef struct packed {
    logic       drain;
    logic       last;
    logic [7:0] data;
  } stream_byte_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       out_ready = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [1:0] kind_o;
  logic [1:0] field_id_o;
  logic [7:0] value_char_o;
  logic       accepted_o;
  logic       final_flag_o;

  bearer_challenge_parser #(
    .KEY_CAP  (KEY_CAP),
    .VALUE_CAP(VALUE_CAP),
    .FIELD_CAP(FIELD_CAP)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte),
    .last_byte_i (last_byte),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .kind_o      (kind_o),
    .field_id_o  (field_id_o),
    .value_char_o(value_char_o),
    .accepted_o  (accepted_o),
    .final_flag_o(final_flag_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // parser state mirror
  phase_e     ph = PH_LEAD;
  int         pfx_cnt = 0;
  logic [3:0] cand = ALL_NAMES;
  int         key_len = 0;
  int         val_len = 0;
  logic [1:0] cur_fld = FLD_REALM;
  bit         fld_known = 1'b0;
  bit         esc_pend = 1'b0;
  bit         failed = 1'b0;
  bit         realm_seen = 1'b0;

  res_t         challenge_results_q[$];
  stream_byte_t header_stream_q[$];
  logic [7:0]   header_buf[$];

  int bytes_done = 0;
  int headers_done = 0;
  int headers_ok = 0;
  int results_seen = 0;
  int mismatches = 0;
  int drain_pauses = 0;
  int burst_left = 8;
  int gap_left = 0;
  int idle_cycles = 0;
  int rx_cycle = 0;
  int ready_pct = 100;
  stream_byte_t nxt;
  res_t want, got;

  function automatic bit blank(logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB);
  endfunction

  function automatic logic [7:0] fold_case(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic int name_size(logic [1:0] fid);
    return (fid == FLD_SERVICE) ? 7 : 5;
  endfunction

  function automatic logic [7:0] name_letter(logic [1:0] fid, int idx);
    logic [55:0] txt;
    case (fid)
      FLD_REALM:   txt = "realm  ";
      FLD_SERVICE: txt = "service";
      FLD_SCOPE:   txt = "scope  ";
      default:     txt = "error  ";
    endcase
    return txt[8*(6-idx) +: 8];
  endfunction

  function automatic void add_result(logic [1:0] kind, logic [1:0] fid, logic [7:0] ch,
                                     logic acc, logic fin);
    res_t r;
    r.kind = kind;
    r.field_id = fid;
    r.value_char = ch;
    r.accepted = acc;
    r.final_flag = fin;
    challenge_results_q.push_back(r);
  endfunction

  function automatic void clear_parser();
    ph = PH_LEAD;
    pfx_cnt = 0;
    cand = ALL_NAMES;
    key_len = 0;
    val_len = 0;
    cur_fld = FLD_REALM;
    fld_known = 1'b0;
    esc_pend = 1'b0;
    failed = 1'b0;
    realm_seen = 1'b0;
  endfunction

  function automatic void close_key();
    int j;
    fld_known = 1'b0;
    val_len = 0;
    for (j = 0; j < 4; j++) begin
      if (cand[j] && key_len == name_size(2'(j))) begin
        fld_known = 1'b1;
        cur_fld = 2'(j);
      end
    end
    if (fld_known) begin
      if (cur_fld == FLD_REALM) realm_seen = 1'b0;
      add_result(KIND_START, cur_fld, 8'h00, 1'b0, 1'b0);
    end
  endfunction

  function automatic void take_key_char(logic [7:0] c);
    int j;
    if (key_len + 1 >= KEY_CAP) begin
      failed = 1'b1;
      return;
    end
    for (j = 0; j < 4; j++) begin
      if (key_len >= name_size(2'(j))) cand[j] = 1'b0;
      else if (fold_case(c) != name_letter(2'(j), key_len)) cand[j] = 1'b0;
    end
    key_len++;
  endfunction

  function automatic void take_value_char(logic [7:0] c);
    if (val_len + 1 >= VALUE_CAP) begin
      failed = 1'b1;
      return;
    end
    val_len++;
    if (!fld_known) return;
    if (val_len >= FIELD_CAP) begin
      failed = 1'b1;
      return;
    end
    if (cur_fld == FLD_REALM) realm_seen = 1'b1;
    add_result(KIND_VALUE, cur_fld, c, 1'b0, 1'b0);
  endfunction

  function automatic void take_token_char(logic [7:0] c);
    if (c == CH_COMMA) ph = PH_LIST;
    else if (blank(c)) ph = PH_AFTER_PARAM;
    else begin
      ph = PH_TOKEN;
      take_value_char(c);
    end
  endfunction

  function automatic void parse_byte(logic [7:0] c, logic last);
    if (!failed) begin
      case (ph)
        PH_LEAD, PH_PREFIX: begin
          if (!(ph == PH_LEAD && blank(c))) begin
            if (pfx_cnt < 6 && fold_case(c) == BEARER_TXT[8*(5-pfx_cnt) +: 8]) begin
              pfx_cnt++;
              ph = (pfx_cnt == 6) ? PH_AFTER_PREFIX : PH_PREFIX;
            end else begin
              failed = 1'b1;
            end
          end
        end
        PH_AFTER_PREFIX: begin
          if (blank(c)) ph = PH_LIST;
          else failed = 1'b1;
        end
        PH_LIST: begin
          if (!(blank(c) || c == CH_COMMA)) begin
            if (c == CH_EQ) failed = 1'b1;
            else begin
              cand = ALL_NAMES;
              key_len = 0;
              ph = PH_KEY;
              take_key_char(c);
            end
          end
        end
        PH_KEY: begin
          if (c == CH_EQ) begin
            close_key();
            ph = PH_EQ_WS;
          end else if (c == CH_COMMA) begin
            close_key();
            ph = PH_LIST;
          end else if (blank(c)) begin
            close_key();
            ph = PH_KEY_WS;
          end else begin
            take_key_char(c);
          end
        end
        PH_KEY_WS: begin
          if (!blank(c)) begin
            if (c == CH_EQ) ph = PH_EQ_WS;
            else if (c == CH_COMMA) ph = PH_LIST;
            else failed = 1'b1;
          end
        end
        PH_EQ_WS: begin
          if (!blank(c)) begin
            if (c == CH_DQUOTE) begin
              esc_pend = 1'b0;
              ph = PH_QUOTED;
            end else begin
              take_token_char(c);
            end
          end
        end
        PH_TOKEN: take_token_char(c);
        PH_QUOTED: begin
          if (esc_pend) begin
            esc_pend = 1'b0;
            take_value_char(c);
          end else if (c == CH_DQUOTE) ph = PH_AFTER_PARAM;
          else if (c == CH_BSLASH) esc_pend = 1'b1;
          else take_value_char(c);
        end
        PH_AFTER_PARAM: begin
          if (!blank(c)) begin
            if (c == CH_COMMA) ph = PH_LIST;
            else failed = 1'b1;
          end
        end
        default: failed = 1'b1;
      endcase
    end
    if (last) begin
      if (!failed) begin
        if (ph == PH_LEAD || ph == PH_PREFIX || ph == PH_QUOTED) failed = 1'b1;
        else if (ph == PH_KEY) close_key();
      end
      add_result(KIND_FINAL, FLD_REALM, 8'h00, !failed && realm_seen, 1'b1);
      headers_done++;
      if (!failed && realm_seen) headers_ok++;
      clear_parser();
    end
  endfunction

  // header generation
  function automatic logic [7:0] any_case(logic [7:0] c);
    return ($urandom_range(0, 1) && c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic void emit(logic [7:0] c);
    header_buf.push_back(($urandom_range(0, 249) == 0) ? 8'($urandom_range(0, 255)) : c);
  endfunction

  function automatic void emit_blanks(int lo, int hi);
    int n, i;
    n = $urandom_range(lo, hi);
    for (i = 0; i < n; i++) emit($urandom_range(0, 1) ? CH_SP : CH_TAB);
  endfunction

  function automatic void push_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) header_buf.push_back(s[i]);
  endfunction

  function automatic void emit_token(int n);
    int i;
    logic [7:0] c;
    for (i = 0; i < n; i++) begin
      do begin
        c = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(33, 126))
                                        : 8'($urandom_range(0, 255));
      end while (blank(c) || c == CH_COMMA || (i == 0 && c == CH_DQUOTE));
      emit(c);
    end
  endfunction

  function automatic void emit_quoted(int n);
    int i;
    logic [7:0] c;
    emit(CH_DQUOTE);
    for (i = 0; i < n; i++) begin
      c = 8'($urandom_range(0, 255));
      if (c == CH_DQUOTE || c == CH_BSLASH || $urandom_range(0, 9) == 0) emit(CH_BSLASH);
      emit(c);
    end
    emit(CH_DQUOTE);
  endfunction

  // mode 1: long realm value near the field cap, mode 2: long unknown value
  function automatic void emit_param(int mode);
    int pick, n, i;
    logic [1:0] fid;
    pick = $urandom_range(0, 19);
    if (mode == 1) pick = 0;
    if (mode == 2) pick = 15;
    if (pick < 12) begin
      fid = (pick < 5) ? FLD_REALM : 2'($urandom_range(1, 3));
      for (i = 0; i < name_size(fid); i++) emit(any_case(name_letter(fid, i)));
    end else if (pick < 19) begin
      n = (pick == 18) ? $urandom_range(KEY_CAP - 3, KEY_CAP + 1) : $urandom_range(1, 8);
      for (i = 0; i < n; i++) emit(any_case(8'($urandom_range(97, 122))));
    end
    pick = (mode != 0) ? 9 : $urandom_range(0, 9);
    if (pick == 0) return;
    if (pick == 1) begin
      emit_blanks(1, 2);
      if ($urandom_range(0, 1)) return;
    end
    if (pick == 2) emit_blanks(1, 2);
    emit(CH_EQ);
    if (pick == 2) emit_blanks(0, 2);
    if (mode == 1) n = $urandom_range(FIELD_CAP - 2, FIELD_CAP + 1);
    else if (mode == 2) n = $urandom_range(VALUE_CAP - 3, VALUE_CAP + 1);
    else n = $urandom_range(0, 10);
    if ($urandom_range(0, 1)) emit_quoted(n);
    else emit_token(n);
  endfunction

  function automatic void flush_header(bit drain);
    int i;
    stream_byte_t b;
    for (i = 0; i < header_buf.size(); i++) begin
      b.data = header_buf[i];
      b.last = (i == header_buf.size() - 1);
      b.drain = drain && (i == 0);
      header_stream_q.push_back(b);
    end
    header_buf.delete();
  endfunction

  function automatic void build_header(int mode, bit drain);
    int pick, n, i, p;
    header_buf.delete();
    emit_blanks(0, 2);
    for (i = 0; i < 6; i++) emit(any_case(BEARER_TXT[8*(5-i) +: 8]));
    pick = (mode != 0) ? 99 : $urandom_range(0, 24);
    if (pick == 0) begin
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) void'(header_buf.pop_back());
      if (header_buf.size() == 0) header_buf.push_back("B");
      flush_header(drain);
      return;
    end
    if (pick == 1) header_buf[header_buf.size() - 1 - $urandom_range(0, 5)] =
                     8'($urandom_range(0, 255));
    if (pick == 2) begin
      flush_header(drain);
      return;
    end
    if (pick == 3) emit(8'($urandom_range(33, 126)));
    emit_blanks(1, 2);
    n = (mode != 0) ? $urandom_range(1, 3) : $urandom_range(0, 4);
    for (p = 0; p < n; p++) begin
      if (p > 0) begin
        emit_blanks(0, 1);
        emit(CH_COMMA);
        if ($urandom_range(0, 4) == 0) emit(CH_COMMA);
        emit_blanks(0, 1);
      end
      if (p > 0 && $urandom_range(0, 29) == 0) emit(CH_EQ);
      emit_param((p == 0) ? mode : 0);
    end
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      emit_blanks(0, 1);
      emit("x");
    end else if (pick == 1) begin
      emit(CH_COMMA);
      push_text("realm=\"a");
      if ($urandom_range(0, 1)) emit(CH_BSLASH);
    end else if (pick == 2) begin
      emit_blanks(1, 2);
    end
    flush_header(drain);
  endfunction

  // byte driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        parse_byte(data_byte, last_byte);
        bytes_done++;
      end
      if (!in_valid || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (header_stream_q.size() == 0 ||
                     (header_stream_q[0].drain && challenge_results_q.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          nxt = header_stream_q.pop_front();
          if (nxt.drain) drain_pauses++;
          in_valid <= 1'b1;
          data_byte <= nxt.data;
          last_byte <= nxt.last;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
          end
        end
      end
    end
  end

  // result stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 150 == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pct = 100;
          1: ready_pct = 80;
          2: ready_pct = 40;
          default: ready_pct = 10;
        endcase
      end
      out_ready <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      results_seen++;
      got = {kind_o, field_id_o, value_char_o, accepted_o, final_flag_o};
      if (challenge_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %0d: kind %0d fid %0d char %02h acc %0d fin %0d",
                   results_seen, got.kind, got.field_id, got.value_char, got.accepted,
                   got.final_flag);
      end else begin
        want = challenge_results_q.pop_front();
        if (got.kind != want.kind || got.field_id != want.field_id ||
            got.value_char != want.value_char || got.accepted != want.accepted ||
            got.final_flag != want.final_flag) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch at result %0d: exp kind %0d fid %0d char %02h acc %0d ",
                      "fin %0d, got kind %0d fid %0d char %02h acc %0d fin %0d"},
                     results_seen, want.kind, want.field_id, want.value_char, want.accepted,
                     want.final_flag, got.kind, got.field_id, got.value_char, got.accepted,
                     got.final_flag);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) idle_cycles = 0;
      else if (header_stream_q.size() != 0 || in_valid || challenge_results_q.size() != 0)
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("no progress for %0d cycles", STALL_LIMIT);
        $display("bearer_challenge_parser_test: FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int h;
    // escapes, extreme bytes, short prefix, key at end
    push_text("\tbEaReR realm=\"a\\\"");
    header_buf.push_back(8'h00);
    header_buf.push_back(8'hff);
    push_text("\\\\\"");
    flush_header(1'b0);
    push_text("Bea");
    flush_header(1'b0);
    push_text("Bearer realm");
    flush_header(1'b0);
    h = 0;
    while (header_stream_q.size() < 1900) begin
      build_header((h == 3) ? 1 : (h == 9) ? 2 : 0, (h % 15) == 7);
      h++;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (header_stream_q.size() != 0 || in_valid || challenge_results_q.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("sent %0d bytes in %0d headers (%0d accepted), %0d drain pauses",
             bytes_done, headers_done, headers_ok, drain_pauses);
    $display("checked %0d results, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && challenge_results_q.size() == 0) begin
      $display("bearer_challenge_parser_test: PASS");
    end else begin
      $display("bearer_challenge_parser_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/bcp_pkg.sv
src/bcp_core.sv
src/bcp_res_fifo.sv
src/bearer_challenge_parser.sv
sim/bearer_challenge_parser_test.sv
